### rtl/base36_digit_encoder_top_macros.svh
// Assertion macros for the base-36 digit encoder.
// Taken in by the top level; the macros expect clk and rst in scope.
`ifndef BASE36_DIGIT_ENCODER_TOP_MACROS_SVH
`define BASE36_DIGIT_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define B36_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define B36_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/b36enc_pkg.sv
// Shared constants, types and the digit-to-ASCII function of the base-36 encoder.
// Used by the front, queue, back and top modules; depends on nothing.
package b36enc_pkg;

  localparam int VALUE_W             = 64;
  localparam int NUM_DIGITS          = 13;
  localparam int DIGIT_W             = 6;
  localparam int IDX_W               = 4;
  localparam int CHAR_W              = 7;
  localparam int RADIX               = 36;
  localparam int HALF_RADIX          = 18;
  localparam int BITS_PER_STEP       = 4;
  localparam int STEPS               = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W          = $clog2(STEPS);
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO        = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 7'd55;  // 'A' - 10
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS  = 6'd10;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

  // One converted value: digits least significant first, index of the top digit
  typedef struct packed {
    digit_vec_t        digits;
    logic [IDX_W-1:0]  top;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(digit_t d);
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + {1'b0, d};
    end else begin
      return CHAR_LETTER_BASE + {1'b0, d};
    end
  endfunction

endpackage

### rtl/base36_digit_encoder_top.sv
// Base-36 encoder: a value is accepted and, if nonzero, converted 4 bits a cycle
// through the digit doubler. Each value then yields 1 to 13 characters on back-to-back
// cycles; the queue (2 entries by default) overlaps the two halves.
// Synchronous active-high reset clears the control state; no output beat during reset.
// Depends on b36enc_pkg, b36enc_front, b36enc_queue, b36enc_back and the macro header.
`include "base36_digit_encoder_top_macros.svh"

module base36_digit_encoder_top #(
  parameter int QUEUE_DEPTH = b36enc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [b36enc_pkg::VALUE_W-1:0]    value,
  output logic                              busy,
  output logic                              char_strobe,
  output logic [b36enc_pkg::CHAR_W-1:0]     char_code,
  output logic                              last
);

  logic                     fe_push;
  b36enc_pkg::item_t        fe_item;
  logic                     be_pop;
  b36enc_pkg::item_t        q_item;
  b36enc_pkg::q_status_t    q_status;

  b36enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .push      (fe_push),
    .push_item (fe_item),
    .q_status  (q_status)
  );

  b36enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fe_push),
    .push_item (fe_item),
    .pop       (be_pop),
    .pop_item  (q_item),
    .q_status  (q_status)
  );

  b36enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_item    (q_item),
    .q_status    (q_status),
    .pop         (be_pop),
    .char_strobe (char_strobe),
    .char_code   (char_code),
    .last        (last)
  );

  // Checks
  `B36_ASSERT_IMP(a_no_push_full, fe_push, !q_status.full, "push into full queue")
  `B36_ASSERT_IMP(a_no_pop_empty, be_pop, !q_status.empty, "pop from empty queue")
  `B36_ASSERT_NXT(a_run_unbroken, char_strobe && !last, char_strobe, "gap inside a run")
  `B36_ASSERT_NXT(a_conv_busy, start && !busy && (value != '0), busy, "converter not busy")

endmodule

### rtl/b36enc_front.sv
// Front end: accepts a value, sorts out zero, and converts it to base-36 digits
// four bits per cycle with a carry-save doubling of all digits. Uses b36enc_pkg.
module b36enc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [b36enc_pkg::VALUE_W-1:0]      value,
  output logic                                busy,
  output logic                                push,
  output b36enc_pkg::item_t                   push_item,
  input  b36enc_pkg::q_status_t               q_status
);

  typedef enum logic [1:0] {IDLE, CONV, HOLD} state_t;

  state_t                                  state;
  logic [b36enc_pkg::STEP_CNT_W-1:0]       cnt;
  logic [b36enc_pkg::VALUE_W-1:0]          shreg;
  b36enc_pkg::digit_vec_t                  digits;
  b36enc_pkg::digit_vec_t                  digits_next;
  b36enc_pkg::digit_vec_t                  acc;
  logic [b36enc_pkg::NUM_DIGITS-1:0]       carry;
  logic [b36enc_pkg::NUM_DIGITS-1:0]       cin;
  logic [b36enc_pkg::DIGIT_W:0]            wide;
  b36enc_pkg::digit_vec_t                  out_digits;
  logic [b36enc_pkg::IDX_W-1:0]            out_top;
  logic                                    conv_last;
  logic                                    accept;

  // Four doubling steps: carry out of a digit depends only on that digit (>= 18)
  always_comb begin
    acc   = digits;
    carry = '0;
    cin   = '0;
    wide  = '0;
    for (int j = 0; j < b36enc_pkg::BITS_PER_STEP; j++) begin
      for (int i = 0; i < b36enc_pkg::NUM_DIGITS; i++) begin
        carry[i] = (acc[i] >= b36enc_pkg::DIGIT_W'(b36enc_pkg::HALF_RADIX));
      end
      cin = {carry[b36enc_pkg::NUM_DIGITS-2:0], shreg[b36enc_pkg::VALUE_W-1-j]};
      for (int i = 0; i < b36enc_pkg::NUM_DIGITS; i++) begin
        wide = {acc[i], cin[i]};
        if (carry[i]) begin
          wide = wide - (b36enc_pkg::DIGIT_W+1)'(b36enc_pkg::RADIX);
        end
        acc[i] = wide[b36enc_pkg::DIGIT_W-1:0];
      end
    end
    digits_next = acc;
  end

  assign conv_last = (state == CONV) &&
                     (cnt == b36enc_pkg::STEP_CNT_W'(b36enc_pkg::STEPS - 1));
  assign push      = (conv_last || (state == HOLD)) && !q_status.full;
  assign busy      = !((state == IDLE) || push);
  assign accept    = start && !busy;

  // Outgoing item and the index of its most significant nonzero digit
  always_comb begin
    out_digits = conv_last ? digits_next : digits;
    out_top    = '0;
    for (int i = 0; i < b36enc_pkg::NUM_DIGITS; i++) begin
      if (out_digits[i] != '0) begin
        out_top = b36enc_pkg::IDX_W'(i);
      end
    end
    push_item.digits = out_digits;
    push_item.top    = out_top;
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      priority if (accept) begin
        state  <= (value == '0) ? HOLD : CONV;
        shreg  <= value;
        digits <= '0;
        cnt    <= '0;
      end else if (state == CONV) begin
        state  <= push ? IDLE : (conv_last ? HOLD : CONV);
        shreg  <= shreg << b36enc_pkg::BITS_PER_STEP;
        digits <= digits_next;
        cnt    <= cnt + 1'b1;
      end else begin
        state  <= push ? IDLE : state;
      end
    end
  end

endmodule

### rtl/b36enc_queue.sv
// Short FIFO of converted items between the front and back ends.
// Uses b36enc_pkg for the item and status types.
module b36enc_queue #(
  parameter int DEPTH = b36enc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  b36enc_pkg::item_t      push_item,
  input  logic                   pop,
  output b36enc_pkg::item_t      pop_item,
  output b36enc_pkg::q_status_t  q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b36enc_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_item       = entries[rd_ptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/b36enc_back.sv
// Back end: takes converted items off the queue and sends their characters,
// most significant digit first, one beat per cycle within an item. Uses b36enc_pkg.
module b36enc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  b36enc_pkg::item_t                 pop_item,
  input  b36enc_pkg::q_status_t             q_status,
  output logic                              pop,
  output logic                              char_strobe,
  output logic [b36enc_pkg::CHAR_W-1:0]     char_code,
  output logic                              last
);

  logic                             active;
  logic [b36enc_pkg::IDX_W-1:0]     idx;
  b36enc_pkg::digit_vec_t           digits;

  // Next item is taken in the same cycle as the final digit of the current one is registered
  assign pop = !q_status.empty && (!active || (idx == '0));

  // Emit registers and the digit walk
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      char_strobe <= 1'b0;
    end else begin
      char_strobe <= active;
      if (active) begin
        char_code <= b36enc_pkg::digit_char(digits[idx]);
        last      <= (idx == '0);
      end
      priority if (pop) begin
        digits <= pop_item.digits;
        idx    <= pop_item.top;
        active <= 1'b1;
      end else if (active && (idx != '0)) begin
        idx    <= idx - 1'b1;
      end else begin
        active <= 1'b0;
      end
    end
  end

endmodule

### sim/base36_digit_encoder_checker.sv
// Checker for the base-36 digit encoder: watches the value and character channels,
// predicts the character run of every accepted value and compares it beat by beat.
// Depends on b36enc_pkg for the port widths.
`timescale 1ns / 100ps

module base36_digit_encoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [b36enc_pkg::VALUE_W-1:0]  value,
  input  logic                            char_strobe,
  input  logic [b36enc_pkg::CHAR_W-1:0]   char_code,
  input  logic                            last,
  output int                              fail_count,
  output int                              chars_pending
);

  typedef struct packed {
    logic [b36enc_pkg::CHAR_W-1:0] code;
    logic                          last;
  } char_beat_t;

  localparam string DIGIT_ALPHABET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam logic [b36enc_pkg::VALUE_W-1:0] BASE = 64'd36;

  char_beat_t expected_chars[$];
  int         fails = 0;

  assign fail_count = fails;

  initial chars_pending = 0;

  // Render one value in base 36, most significant digit first, onto the queue
  task automatic push_base36_text(input logic [b36enc_pkg::VALUE_W-1:0] v);
    logic [b36enc_pkg::CHAR_W-1:0]  digits_msb_first[$];
    logic [b36enc_pkg::VALUE_W-1:0] rest;
    byte                            ch;
    char_beat_t                     beat;
    int                             k;
    rest = v;
    // zero still yields one '0' digit
    do begin
      ch = DIGIT_ALPHABET[int'(rest % BASE)];
      digits_msb_first.push_front(ch[b36enc_pkg::CHAR_W-1:0]);
      rest = rest / BASE;
    end while (rest != 0);
    for (k = 0; k < digits_msb_first.size(); k++) begin
      beat.code = digits_msb_first[k];
      beat.last = (k == digits_msb_first.size() - 1);
      expected_chars = {expected_chars, beat};
    end
  endtask

  // Predict on each accepted value, compare each character beat
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (start && !busy) begin
        push_base36_text(value);
      end
      if (char_strobe) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected char beat: char_code %0d last %0d", char_code, last);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, char_code);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fails++;
          end
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

### sim/base36_digit_encoder_top_tb.sv
// Testbench top for the base-36 digit encoder: clock, reset, value stimulus and verdict.
// Depends on b36enc_pkg, base36_digit_encoder_top and base36_digit_encoder_checker.
`timescale 1ns / 100ps

module base36_digit_encoder_top_tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 118;
  localparam int NUM_PHASES      = 4;
  localparam int MAX_GAP         = 40;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic [b36enc_pkg::VALUE_W-1:0] value;
  logic                          busy;
  logic                          char_strobe;
  logic [b36enc_pkg::CHAR_W-1:0] char_code;
  logic                          last;
  int                            fail_count;
  int                            chars_pending;
  int                            cycle_count = 0;

  // idle percentage of the sender per phase; the receiver cannot stall
  int sender_idle_pct[NUM_PHASES] = '{0, 64, 0, 38};

  base36_digit_encoder_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .value       (value),
    .busy        (busy),
    .char_strobe (char_strobe),
    .char_code   (char_code),
    .last        (last)
  );

  base36_digit_encoder_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .char_strobe   (char_strobe),
    .char_code     (char_code),
    .last          (last),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [b36enc_pkg::VALUE_W-1:0] pow36(input int k);
    logic [b36enc_pkg::VALUE_W-1:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd36;
    return p;
  endfunction

  // Mix of full-width, shortened, radix-power edge and small values
  function automatic logic [b36enc_pkg::VALUE_W-1:0] random_value();
    logic [b36enc_pkg::VALUE_W-1:0] v;
    case ($urandom_range(5))
      0, 1: v = {$urandom, $urandom};
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: v = pow36($urandom_range(12)) + 64'($urandom_range(2)) - 64'd1;
      4: v = 64'($urandom_range(1295));
      default: v = pow36($urandom_range(1, 12)) - 64'd1;  // all 'Z' digits
    endcase
    return v;
  endfunction

  // Hold one value on the port until its accept beat, then maybe idle
  task automatic send_value(input logic [b36enc_pkg::VALUE_W-1:0] v, input int idle_pct);
    int gap;
    gap = 0;
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      value <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [b36enc_pkg::VALUE_W-1:0] directed[$];
    int phase;
    rst   <= 1'b1;
    start <= 1'b0;
    value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, digit boundaries, widest runs, bit patterns
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd35, 64'd36, 64'd37, 64'd1295,
                 64'd1296, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h0123_4567_89AB_CDEF};
    directed = {directed, pow36(12) - 64'd1};
    directed = {directed, pow36(12)};
    directed = {directed, pow36(12) + 64'd1};
    directed = {directed, pow36(6)};
    directed = {directed, pow36(7) - 64'd1};
    foreach (directed[i]) send_value(directed[i], 0);

    // Random values through each idling phase
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      repeat (RANDOM_PER_PHASE) send_value(random_value(), sender_idle_pct[phase]);
    end
    start <= 1'b0;
    @(posedge clk);

    // Drain outstanding characters, then watch for strays
    wait (chars_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && chars_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### base36_digit_encoder_top.f
+incdir+rtl
rtl/b36enc_pkg.sv
rtl/b36enc_front.sv
rtl/b36enc_queue.sv
rtl/b36enc_back.sv
rtl/base36_digit_encoder_top.sv
sim/base36_digit_encoder_checker.sv
sim/base36_digit_encoder_top_tb.sv
